FILE: rtl/mls_pkg.sv
package mls_pkg;

    localparam int PORTS_PER_SIDE = 16;
    localparam int PORT_W         = 4;
    localparam int MAC_W          = 48;
    localparam int MASK_W         = 32;
    localparam int LOC_W          = 5;
    localparam int AGE_W          = 3;
    localparam int CFG_IDX_W      = 2;
    localparam int CFG_DATA_W     = 32;
    localparam int COUNT_DEPTH    = 32;

    localparam int DEF_TABLE_ENTRIES = 4096;
    localparam int DEF_WAYS          = 4;
    localparam int DEF_STAMP_WIDTH   = 32;

    localparam logic [31:0] CRC32C_POLY   = 32'h82F63B78;
    localparam logic [43:0] RESERVED_PFX  = 44'h0180C200000;

    localparam logic [CFG_IDX_W-1:0] CFG_WEST      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_EAST      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CONNECTED = 2'd2;

    typedef enum logic [2:0] {
        VD_FILTERED = 3'd0,
        VD_UNICAST  = 3'd1,
        VD_MCAST    = 3'd2,
        VD_MISS     = 3'd3,
        VD_STALE    = 3'd4,
        VD_UNLINK   = 3'd5
    } t_verdict;

    typedef struct packed {
        logic              req_type;
        logic              side;
        logic [PORT_W-1:0] port;
        logic [MAC_W-1:0]  dst_mac;
        logic [MAC_W-1:0]  src_mac;
    } t_in_item;

    typedef struct packed {
        logic [MASK_W-1:0] egress_mask;
        t_verdict          verdict;
    } t_out_item;

    // CRC32C, seed zero, no final inversion, over the six MAC bytes in wire
    // order followed by two zero bytes; bits enter LSB first per byte.
    function automatic logic [31:0] crc32c_key(input logic [MAC_W-1:0] mac);
        logic [31:0] crc;
        logic [7:0]  byte_v;
        logic [63:0] msg;
        crc = 32'd0;
        msg = {mac, 16'd0};
        for (int k = 0; k < 8; k++) begin
            byte_v = msg[(56 - 8 * k) +: 8];
            crc = crc ^ {24'd0, byte_v};
            for (int b = 0; b < 8; b++) begin
                crc = (crc >> 1) ^ (crc[0] ? CRC32C_POLY : 32'd0);
            end
        end
        return crc;
    endfunction

    // Ports in use on one side: the low n bits, n saturated at the side width.
    function automatic logic [PORTS_PER_SIDE-1:0] side_in_use(input logic [4:0] n);
        logic [PORTS_PER_SIDE:0] t;
        logic [4:0]              nc;
        nc = (n > 5'(PORTS_PER_SIDE)) ? 5'(PORTS_PER_SIDE) : n;
        t  = ((PORTS_PER_SIDE + 1)'(1) << nc) - (PORTS_PER_SIDE + 1)'(1);
        return t[PORTS_PER_SIDE-1:0];
    endfunction

endpackage

FILE: rtl/mls_ram.sv
module mls_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/mls_setmod.sv
module mls_setmod #(
    parameter int SETS = 1024
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic [31:0]             i_crc,
    output logic                    o_busy,
    output logic [$clog2(SETS)-1:0] o_set
);

    localparam int SET_W = $clog2(SETS);
    localparam int SHIFT = 32 + SET_W;
    localparam logic [63:0] RECIP_WIDE = (64'd1 << SHIFT) / 64'(SETS);
    localparam logic [32:0] RECIP      = RECIP_WIDE[32:0];
    localparam logic [SET_W:0] SETS_LOW = (SET_W + 1)'(SETS);

    logic [31:0]      r_x, n_x;
    logic [SET_W:0]   r_quot, n_quot;
    logic [SET_W:0]   r_raw, n_raw;
    logic             r_step, n_step;
    logic             r_busy, n_busy;
    logic [64:0]      prod;
    logic [SET_W:0]   qs_low;

    // Reciprocal multiplication: the estimated quotient is at most one low,
    // so the raw remainder is below twice the set count and one compare and
    // subtract on the output finishes it. Only the low bits of the quotient
    // times the set count matter for the remainder.
    always_comb begin
        n_x    = r_x;
        n_quot = r_quot;
        n_raw  = r_raw;
        n_step = r_step;
        n_busy = r_busy;
        prod   = 65'(r_x) * 65'(RECIP);
        qs_low = r_quot * SETS_LOW;
        if (i_start) begin
            n_x    = i_crc;
            n_step = 1'b0;
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (!r_step) begin
                n_quot = prod[SHIFT +: SET_W + 1];
                n_step = 1'b1;
            end else begin
                n_raw  = r_x[SET_W:0] - qs_low;
                n_busy = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_step <= n_step;
        end
        r_x    <= n_x;
        r_quot <= n_quot;
        r_raw  <= n_raw;
    end

    assign o_busy = r_busy;
    assign o_set  = (r_raw >= SETS_LOW) ? SET_W'(r_raw - SETS_LOW) : r_raw[SET_W-1:0];

endmodule

FILE: rtl/mac_learning_switch.sv
// MAC learning bridge with a west and an east side of ports. Each input
// transaction is either a packet (learn its source MAC against ingress side,
// port and that port's unlink count, then pick egress ports) or an unlink
// notification (bump that port's saturating count). One result transaction
// leaves per input. Items are processed one at a time. With the output free,
// a result is valid soonest for an unlink or for a packet that is filtered or
// flooded as group traffic, later for a destination miss and last for a
// destination hit. The hash state reduces both MACs' CRC32C to a set index
// (a reciprocal multiply, then a remainder with a final compare and
// subtract) and issues the source row and ingress count reads; the rest are
// reads and write-backs of the set row memory, which has one read and one
// write port with a registered read, and of the unlink count memory, then
// the output register is loaded. The input is ready again in the cycle the
// result turns valid. After reset a clearing pass zeroes the tables; no
// input is accepted until it ends, while configuration writes are taken at
// any time. The input can be accepted again while a finished result still
// waits on the output.
module mac_learning_switch #(
    parameter int TABLE_ENTRIES = mls_pkg::DEF_TABLE_ENTRIES,
    parameter int WAYS          = mls_pkg::DEF_WAYS,
    parameter int STAMP_WIDTH   = mls_pkg::DEF_STAMP_WIDTH
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  mls_pkg::t_in_item                   i_item,
    output logic                                o_valid,
    input  logic                                i_ready,
    output mls_pkg::t_out_item                  o_item,
    input  logic                                i_cfg_we,
    input  logic [mls_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [mls_pkg::CFG_DATA_W-1:0]      i_cfg_data
);

    localparam int SETS    = TABLE_ENTRIES / WAYS;
    localparam int SET_W   = $clog2(SETS);
    localparam int WAY_W   = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int MAC_W   = mls_pkg::MAC_W;
    localparam int LOC_W   = mls_pkg::LOC_W;
    localparam int AGE_W   = mls_pkg::AGE_W;
    localparam int MASK_W  = mls_pkg::MASK_W;
    // Entry: {valid, mac, location, stamp}
    localparam int EW      = 1 + MAC_W + LOC_W + STAMP_WIDTH;
    localparam int LOC_LSB = STAMP_WIDTH;
    localparam int MAC_LSB = STAMP_WIDTH + LOC_W;
    localparam int VLD_BIT = STAMP_WIDTH + LOC_W + MAC_W;
    localparam int AGE_LSB = WAYS * EW;
    localparam int ROW_W   = WAYS * EW + AGE_W * WAYS;
    localparam int CNT_AW  = $clog2(mls_pkg::COUNT_DEPTH);
    localparam int CLR_LEN = (SETS > mls_pkg::COUNT_DEPTH) ? SETS : mls_pkg::COUNT_DEPTH;
    localparam int CLR_W   = $clog2(CLR_LEN) + 1;
    localparam logic [STAMP_WIDTH-1:0] STAMP_MAX = '1;

    typedef enum logic [8:0] {
        ST_CLEAR = 9'b000000001,
        ST_IDLE  = 9'b000000010,
        ST_HASH  = 9'b000000100,
        ST_LEARN = 9'b000001000,
        ST_RDDST = 9'b000010000,
        ST_LOOK  = 9'b000100000,
        ST_COUNT = 9'b001000000,
        ST_DONE  = 9'b010000000,
        ST_UNLNK = 9'b100000000
    } t_state;

    t_state                     r_state, n_state;
    logic [CLR_W-1:0]           r_clr_addr;
    mls_pkg::t_in_item          r_req;
    logic [STAMP_WIDTH-1:0]     r_hit_stamp;
    logic [LOC_W-1:0]           r_hit_loc;
    mls_pkg::t_out_item         r_res, n_res;
    logic                       r_out_valid;
    mls_pkg::t_out_item         r_out;
    logic [4:0]                 r_west_ports;
    logic [4:0]                 r_east_ports;
    logic [MASK_W-1:0]          r_connected;

    // Set index units, one per MAC
    logic                       src_busy, dst_busy;
    logic [SET_W-1:0]           src_set, dst_set;
    logic                       accept;

    assign accept = i_valid && o_ready;

    mls_setmod #(.SETS(SETS)) u_src_set (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (accept),
        .i_crc   (mls_pkg::crc32c_key(i_item.src_mac)),
        .o_busy  (src_busy),
        .o_set   (src_set)
    );

    mls_setmod #(.SETS(SETS)) u_dst_set (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (accept),
        .i_crc   (mls_pkg::crc32c_key(i_item.dst_mac)),
        .o_busy  (dst_busy),
        .o_set   (dst_set)
    );

    // Set row memory and unlink count memory
    logic                       tab_we;
    logic [SET_W-1:0]           tab_waddr, tab_raddr;
    logic [ROW_W-1:0]           tab_wdata, tab_rdata;
    logic                       cnt_we;
    logic [CNT_AW-1:0]          cnt_waddr, cnt_raddr;
    logic [STAMP_WIDTH-1:0]     cnt_wdata, cnt_rdata;

    mls_ram #(.WIDTH(ROW_W), .DEPTH(SETS)) u_table (
        .i_clk   (i_clk),
        .i_we    (tab_we),
        .i_waddr (tab_waddr),
        .i_wdata (tab_wdata),
        .i_raddr (tab_raddr),
        .o_rdata (tab_rdata)
    );

    mls_ram #(.WIDTH(STAMP_WIDTH), .DEPTH(mls_pkg::COUNT_DEPTH)) u_counts (
        .i_clk   (i_clk),
        .i_we    (cnt_we),
        .i_waddr (cnt_waddr),
        .i_wdata (cnt_wdata),
        .i_raddr (cnt_raddr),
        .o_rdata (cnt_rdata)
    );

    // Move a way to newest; ways younger than its old rank age by one.
    function automatic logic [ROW_W-1:0] touch(
        input logic [ROW_W-1:0] row,
        input logic [WAY_W-1:0] way,
        input logic             was_valid
    );
        logic [ROW_W-1:0] r;
        logic [AGE_W:0]   old;
        logic [AGE_W-1:0] a;
        r   = row;
        old = was_valid ? {1'b0, row[AGE_LSB + AGE_W * way +: AGE_W]} : (AGE_W + 1)'(WAYS);
        for (int v = 0; v < WAYS; v++) begin
            a = row[AGE_LSB + AGE_W * v +: AGE_W];
            if (WAY_W'(v) != way && row[EW * v + VLD_BIT] && {1'b0, a} < old) begin
                r[AGE_LSB + AGE_W * v +: AGE_W] = a + AGE_W'(1);
            end
        end
        r[AGE_LSB + AGE_W * way +: AGE_W] = '0;
        return r;
    endfunction

    // Source learning on the row read from the source set
    logic [ROW_W-1:0]           learn_row;
    logic                       l_found, l_inv, l_was_valid;
    logic [WAY_W-1:0]           l_way;
    logic [AGE_W-1:0]           l_oldest;

    always_comb begin
        l_found  = 1'b0;
        l_inv    = 1'b0;
        l_way    = '0;
        l_oldest = '0;
        for (int w = 0; w < WAYS; w++) begin
            if (!l_found && tab_rdata[EW * w + VLD_BIT]
                && tab_rdata[EW * w + MAC_LSB +: MAC_W] == r_req.src_mac) begin
                l_found = 1'b1;
                l_way   = WAY_W'(w);
            end
        end
        if (!l_found) begin
            for (int w = 0; w < WAYS; w++) begin
                if (!l_inv && !tab_rdata[EW * w + VLD_BIT]) begin
                    l_inv = 1'b1;
                    l_way = WAY_W'(w);
                end
            end
            if (!l_inv) begin
                for (int w = 0; w < WAYS; w++) begin
                    if (tab_rdata[AGE_LSB + AGE_W * w +: AGE_W] > l_oldest) begin
                        l_oldest = tab_rdata[AGE_LSB + AGE_W * w +: AGE_W];
                        l_way    = WAY_W'(w);
                    end
                end
            end
        end
        l_was_valid = tab_rdata[EW * l_way + VLD_BIT];
        learn_row   = tab_rdata;
        learn_row[EW * l_way +: EW] = {1'b1, r_req.src_mac, r_req.side, r_req.port, cnt_rdata};
        learn_row   = touch(learn_row, l_way, l_was_valid);
    end

    // Destination lookup on the row read from the destination set
    logic                       d_hit;
    logic [WAY_W-1:0]           d_way;

    always_comb begin
        d_hit = 1'b0;
        d_way = '0;
        for (int w = 0; w < WAYS; w++) begin
            if (!d_hit && tab_rdata[EW * w + VLD_BIT]
                && tab_rdata[EW * w + MAC_LSB +: MAC_W] == r_req.dst_mac) begin
                d_hit = 1'b1;
                d_way = WAY_W'(w);
            end
        end
    end

    // Egress masks
    logic [MASK_W-1:0]          ingress_bit, usable;

    assign ingress_bit = MASK_W'(1) << {r_req.side, r_req.port};
    assign usable      = {mls_pkg::side_in_use(r_east_ports),
                          mls_pkg::side_in_use(r_west_ports)}
                         & r_connected & ~ingress_bit;

    // Sequencer
    always_comb begin
        n_state   = r_state;
        n_res     = r_res;
        tab_we    = 1'b0;
        tab_waddr = src_set;
        tab_wdata = learn_row;
        tab_raddr = src_set;
        cnt_we    = 1'b0;
        cnt_waddr = {r_req.side, r_req.port};
        cnt_wdata = (cnt_rdata == STAMP_MAX) ? cnt_rdata : cnt_rdata + STAMP_WIDTH'(1);
        cnt_raddr = {r_req.side, r_req.port};
        case (r_state)
            ST_CLEAR: begin
                // Zero one row and one count per cycle, each while its address is in range
                tab_we    = r_clr_addr < CLR_W'(SETS);
                tab_waddr = r_clr_addr[SET_W-1:0];
                tab_wdata = '0;
                cnt_we    = r_clr_addr < CLR_W'(mls_pkg::COUNT_DEPTH);
                cnt_waddr = r_clr_addr[CNT_AW-1:0];
                cnt_wdata = '0;
                if (r_clr_addr == CLR_W'(CLR_LEN - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    n_state = ST_HASH;
                end
            end
            ST_HASH: begin
                // Source row and ingress count are read here
                if (!src_busy && !dst_busy) begin
                    n_state = r_req.req_type ? ST_UNLNK : ST_LEARN;
                end
            end
            ST_UNLNK: begin
                cnt_we  = 1'b1;
                n_res   = '{egress_mask: '0, verdict: mls_pkg::VD_UNLINK};
                n_state = ST_DONE;
            end
            ST_LEARN: begin
                tab_we = 1'b1;
                if (r_req.dst_mac[MAC_W-1:4] == mls_pkg::RESERVED_PFX) begin
                    n_res   = '{egress_mask: '0, verdict: mls_pkg::VD_FILTERED};
                    n_state = ST_DONE;
                end else if (r_req.dst_mac[40]) begin
                    n_res   = '{egress_mask: usable, verdict: mls_pkg::VD_MCAST};
                    n_state = ST_DONE;
                end else begin
                    n_state = ST_RDDST;
                end
            end
            ST_RDDST: begin
                tab_raddr = dst_set;
                n_state   = ST_LOOK;
            end
            ST_LOOK: begin
                tab_waddr = dst_set;
                tab_wdata = touch(tab_rdata, d_way, 1'b1);
                cnt_raddr = tab_rdata[EW * d_way + LOC_LSB +: LOC_W];
                if (d_hit) begin
                    tab_we  = 1'b1;
                    n_state = ST_COUNT;
                end else begin
                    n_res   = '{egress_mask: usable, verdict: mls_pkg::VD_MISS};
                    n_state = ST_DONE;
                end
            end
            ST_COUNT: begin
                if (r_hit_stamp < cnt_rdata) begin
                    n_res = '{egress_mask: usable, verdict: mls_pkg::VD_STALE};
                end else begin
                    n_res = '{egress_mask: (MASK_W'(1) << r_hit_loc) & usable,
                              verdict: mls_pkg::VD_UNICAST};
                end
                n_state = ST_DONE;
            end
            ST_DONE: begin
                // Hold until the output register is free
                if (!r_out_valid || i_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_CLEAR;
            r_clr_addr   <= '0;
            r_out_valid  <= 1'b0;
            r_west_ports <= 5'd16;
            r_east_ports <= 5'd16;
            r_connected  <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_CLEAR) begin
                r_clr_addr <= r_clr_addr + CLR_W'(1);
            end
            if (r_state == ST_DONE && (!r_out_valid || i_ready)) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    mls_pkg::CFG_WEST:      r_west_ports <= i_cfg_data[4:0];
                    mls_pkg::CFG_EAST:      r_east_ports <= i_cfg_data[4:0];
                    mls_pkg::CFG_CONNECTED: r_connected  <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
        if (accept) begin
            r_req <= i_item;
        end
        if (r_state == ST_LOOK) begin
            r_hit_stamp <= tab_rdata[EW * d_way +: STAMP_WIDTH];
            r_hit_loc   <= tab_rdata[EW * d_way + LOC_LSB +: LOC_W];
        end
        r_res <= n_res;
        if (r_state == ST_DONE && (!r_out_valid || i_ready)) begin
            r_out <= r_res;
        end
    end

    assign o_ready = (r_state == ST_IDLE);
    assign o_valid = r_out_valid;
    assign o_item  = r_out;

    a_no_accept_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CLEAR) |-> !o_ready)
        else $error("input accepted during clearing pass");

    a_no_ingress_egress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE) |-> ((r_res.egress_mask & ingress_bit) == '0))
        else $error("ingress port marked for egress");

    a_mask_connected: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE) |-> ((r_res.egress_mask & ~r_connected) == '0))
        else $error("egress on unconnected port");

    a_empty_mask: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE && (r_res.verdict == mls_pkg::VD_FILTERED
                                || r_res.verdict == mls_pkg::VD_UNLINK))
        |-> (r_res.egress_mask == '0))
        else $error("filtered or unlink result carries ports");

    a_hash_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_HASH && !src_busy) |-> !dst_busy)
        else $error("set index units out of step");

endmodule

FILE: test/tb.sv
module tb;
    import mls_pkg::*;

    localparam int SET_CNT   = DEF_TABLE_ENTRIES / DEF_WAYS;
    localparam int WAY_CNT   = DEF_WAYS;
    localparam int SLOT_CNT  = DEF_TABLE_ENTRIES;
    localparam int RAND_ITEMS = 150;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_valid = 1'b0;
    logic      o_ready;
    t_in_item  i_item = '0;
    logic      o_valid;
    logic      i_ready = 1'b0;
    t_out_item o_item;
    logic      i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = CFG_WEST;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    mac_learning_switch dut (.*);

    always #4 i_clk = ~i_clk;

    initial begin
        #50_000_000;
        $display("timeout at %0t", $time);
        $display("*** FAILED ***");
        $finish;
    end

    // bridge shadow state
    logic [48:0] key_mem [SLOT_CNT];
    logic [4:0]  loc_mem [SLOT_CNT];
    logic [31:0] stamp_mem [SLOT_CNT];
    logic [11:0] rank_mem [SET_CNT];
    logic [31:0] unlinks [32];
    logic [4:0]  west_n, east_n;
    logic [31:0] linked;

    t_out_item verdict_q [$];
    int errors = 0;
    int seen [8];
    int rx_stall_max = 0;
    int tx_gap_max = 0;

    logic [47:0] mac_pool [$];

    function automatic logic [9:0] bucket_of(logic [47:0] mac);
        logic [31:0] c;
        logic [63:0] msg;
        c = '0;
        msg = {mac, 16'h0};
        for (int i = 0; i < 8; i++)
            for (int b = 0; b < 8; b++) begin
                logic fb;
                fb = c[0] ^ msg[63 - 8 * i - 7 + b];
                c = (c >> 1) ^ (fb ? 32'h82F63B78 : 32'h0);
            end
        return c[9:0];
    endfunction

    function automatic logic [2:0] rank(int s, int w);
        return rank_mem[s][3 * w +: 3];
    endfunction

    function automatic void refresh(int s, int w, bit was_valid);
        logic [2:0] old;
        old = was_valid ? rank(s, w) : 3'(WAY_CNT);
        for (int v = 0; v < WAY_CNT; v++)
            if (v != w && key_mem[s * WAY_CNT + v][48] && rank(s, v) < old)
                rank_mem[s][3 * v +: 3] = rank(s, v) + 3'd1;
        rank_mem[s][3 * w +: 3] = 3'd0;
    endfunction

    function automatic int lookup_way(int s, logic [47:0] mac);
        for (int w = 0; w < WAY_CNT; w++)
            if (key_mem[s * WAY_CNT + w] == {1'b1, mac}) return w;
        return -1;
    endfunction

    function automatic logic [31:0] port_mask(logic sd, logic [3:0] p);
        return 32'h1 << {sd, p};
    endfunction

    function automatic logic [31:0] live_ports();
        logic [4:0] w, e;
        w = (west_n > 16) ? 5'd16 : west_n;
        e = (east_n > 16) ? 5'd16 : east_n;
        return {16'((32'h1 << e) - 1), 16'((32'h1 << w) - 1)};
    endfunction

    // Advance the shadow bridge by one transaction and return its verdict.
    function automatic t_out_item bridge_step(t_in_item it);
        t_out_item r;
        int s, w, slot;
        bit was_valid;
        logic [31:0] usable;
        logic [4:0] loc;
        r = '0;
        if (it.req_type) begin
            if (unlinks[{it.side, it.port}] != '1) unlinks[{it.side, it.port}]++;
            r.verdict = VD_UNLINK;
            return r;
        end
        // learn the source
        s = bucket_of(it.src_mac);
        w = lookup_way(s, it.src_mac);
        was_valid = 1'b1;
        if (w < 0) begin
            for (int v = WAY_CNT - 1; v >= 0; v--)
                if (!key_mem[s * WAY_CNT + v][48]) w = v;
            if (w < 0) begin
                logic [2:0] oldest;
                oldest = 0;
                w = 0;
                for (int v = 0; v < WAY_CNT; v++)
                    if (rank(s, v) > oldest) begin
                        oldest = rank(s, v);
                        w = v;
                    end
            end
            was_valid = key_mem[s * WAY_CNT + w][48];
            key_mem[s * WAY_CNT + w] = {1'b1, it.src_mac};
        end
        loc_mem[s * WAY_CNT + w] = {it.side, it.port};
        stamp_mem[s * WAY_CNT + w] = unlinks[{it.side, it.port}];
        refresh(s, w, was_valid);

        usable = live_ports() & linked & ~port_mask(it.side, it.port);
        if (it.dst_mac[47:4] == 44'h0180C200000) begin
            r.verdict = VD_FILTERED;
        end else if (it.dst_mac[40]) begin
            r.verdict = VD_MCAST;
            r.egress_mask = usable;
        end else begin
            s = bucket_of(it.dst_mac);
            w = lookup_way(s, it.dst_mac);
            if (w < 0) begin
                r.verdict = VD_MISS;
                r.egress_mask = usable;
            end else begin
                slot = s * WAY_CNT + w;
                loc = loc_mem[slot];
                refresh(s, w, 1'b1);
                if (stamp_mem[slot] < unlinks[loc]) begin
                    r.verdict = VD_STALE;
                    r.egress_mask = usable;
                end else begin
                    r.verdict = VD_UNICAST;
                    r.egress_mask = port_mask(loc[4], loc[3:0]) & usable;
                end
            end
        end
        return r;
    endfunction

    // Send one transaction; entered and left at a falling edge.
    task automatic send(t_in_item it, bit typed, t_out_item typed_res);
        int gap;
        t_out_item p;
        gap = ($urandom_range(0, 9) < 6) ? 0 :
              ($urandom_range(0, 19) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 4);
        if (gap > tx_gap_max) tx_gap_max = gap;
        if (gap > 0) begin
            i_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid = 1'b1;
        i_item = it;
        do @(posedge i_clk); while (!o_ready);
        p = bridge_step(it);
        verdict_q.push_back(typed ? typed_res : p);
        @(negedge i_clk);
    endtask

    task automatic drain();
        i_valid = 1'b0;
        @(negedge i_clk);
        while (verdict_q.size() > 0) @(negedge i_clk);
        // an unlink or a lookup may still be writing back
        repeat (20) @(negedge i_clk);
    endtask

    task automatic configure(logic [4:0] w, logic [4:0] e, logic [31:0] c);
        i_cfg_we = 1'b1;
        i_cfg_idx = CFG_WEST;      i_cfg_data = 32'(w); @(negedge i_clk);
        i_cfg_idx = CFG_EAST;      i_cfg_data = 32'(e); @(negedge i_clk);
        i_cfg_idx = CFG_CONNECTED; i_cfg_data = c;      @(negedge i_clk);
        i_cfg_we = 1'b0;
        west_n = w;
        east_n = e;
        linked = c;
    endtask

    function automatic logic [47:0] wide_rand();
        return {16'($urandom), $urandom};
    endfunction

    function automatic t_in_item random_item();
        t_in_item it;
        int pick;
        it = '0;
        it.side = 1'($urandom);
        it.port = 4'($urandom);
        if ($urandom_range(0, 99) < 10) begin
            it.req_type = 1'b1;
            it.dst_mac = wide_rand();
            it.src_mac = wide_rand();
            return it;
        end
        it.src_mac = ($urandom_range(0, 99) < 85) ?
                     mac_pool[$urandom_range(0, mac_pool.size() - 1)] : wide_rand();
        pick = $urandom_range(0, 99);
        if (pick < 62)      it.dst_mac = mac_pool[$urandom_range(0, mac_pool.size() - 1)];
        else if (pick < 72) it.dst_mac = wide_rand() | 48'h0100_0000_0000;
        else if (pick < 77) it.dst_mac = '1;
        else if (pick < 83) it.dst_mac = {44'h0180C200000, 4'($urandom)};
        else if (pick < 87) it.dst_mac = {44'h0180C200001, 4'($urandom)};
        else                it.dst_mac = wide_rand();
        return it;
    endfunction

    // Receiver: ready drops for random stretches, with calm phases.
    bit rx_calm = 1'b0;
    initial begin
        int stall;
        stall = 0;
        forever begin
            @(negedge i_clk);
            if (stall > 0) begin
                i_ready = 1'b0;
                stall--;
            end else if (!rx_calm && $urandom_range(0, 3) == 0) begin
                stall = ($urandom_range(0, 15) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 4);
                if (stall > rx_stall_max) rx_stall_max = stall;
                i_ready = 1'b0;
                stall--;
            end else begin
                i_ready = 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (verdict_q.size() == 0) begin
                $display("%0t: unexpected result mask=%h verdict=%0d",
                         $time, o_item.egress_mask, o_item.verdict);
                errors++;
            end else begin
                t_out_item want;
                want = verdict_q.pop_front();
                if (o_item.verdict !== want.verdict) begin
                    $display("%0t: verdict expected %0d got %0d",
                             $time, want.verdict, o_item.verdict);
                    errors++;
                end
                if (o_item.egress_mask !== want.egress_mask) begin
                    $display("%0t: egress_mask expected %h got %h",
                             $time, want.egress_mask, o_item.egress_mask);
                    errors++;
                end
                seen[want.verdict]++;
            end
        end
    end

    typedef struct {
        t_in_item  it;
        bit        typed;
        t_out_item res;
    } t_row;

    localparam logic [47:0] MAC_A = 48'h0200_0000_00A1;
    localparam logic [47:0] MAC_B = 48'h0A1B_2C3D_4E5F;
    localparam logic [47:0] MAC_C = 48'h0012_3456_789A;

    t_row rows [$];

    initial begin
        logic [47:0] m;
        logic [9:0]  hot;
        logic [4:0]  wv, ev;
        t_in_item    it;

        for (int i = 0; i < SLOT_CNT; i++) key_mem[i] = '0;
        for (int i = 0; i < SET_CNT; i++) rank_mem[i] = '0;
        for (int i = 0; i < 32; i++) unlinks[i] = '0;
        west_n = 5'd16;
        east_n = 5'd16;
        linked = '0;

        // MAC pool: six unicast MACs sharing one bucket to force eviction,
        // plus scattered ones
        m = wide_rand() & ~48'h0100_0000_0000;
        hot = bucket_of(m);
        mac_pool.push_back(m);
        while (mac_pool.size() < 6) begin
            m = wide_rand() & ~48'h0100_0000_0000;
            if (bucket_of(m) == hot) mac_pool.push_back(m);
        end
        repeat (24) mac_pool.push_back(wide_rand() & ~48'h0100_0000_0000);

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        configure(5'd16, 5'd16, 32'hFFFF_FFFF);

        // directed rows: req, side, port, dst, src
        rows = '{
            '{'{1'b0, 1'b0, 4'd3, 48'h0180_C200_0000, MAC_A}, 1, '{32'h0, VD_FILTERED}},
            '{'{1'b0, 1'b1, 4'd5, 48'h0180_C200_000F, MAC_B}, 1, '{32'h0, VD_FILTERED}},
            '{'{1'b0, 1'b1, 4'd5, 48'h0180_C200_0010, MAC_B}, 0, '{32'h0, VD_FILTERED}},
            '{'{1'b0, 1'b0, 4'd3, 48'hFFFF_FFFF_FFFF, MAC_A}, 0, '{32'h0, VD_FILTERED}},
            '{'{1'b0, 1'b1, 4'd5, MAC_A, MAC_B},              0, '{32'h0, VD_FILTERED}},
            '{'{1'b1, 1'b0, 4'd3, 48'h0, 48'h0},              1, '{32'h0, VD_UNLINK}},
            '{'{1'b0, 1'b1, 4'd5, MAC_A, MAC_B},              0, '{32'h0, VD_FILTERED}},
            '{'{1'b0, 1'b1, 4'd5, MAC_C, MAC_B},              0, '{32'h0, VD_FILTERED}},
            '{'{1'b0, 1'b0, 4'd3, MAC_B, MAC_A},              0, '{32'h0, VD_FILTERED}},
            '{'{1'b0, 1'b1, 4'd5, MAC_A, MAC_B},              0, '{32'h0, VD_FILTERED}},
            '{'{1'b0, 1'b1, 4'd15, 48'h0, 48'hFFFF_FFFF_FFFF}, 0, '{32'h0, VD_FILTERED}},
            '{'{1'b0, 1'b0, 4'd0, 48'hFFFF_FFFF_FFFF, 48'h0}, 0, '{32'h0, VD_FILTERED}},
            '{'{1'b0, 1'b1, 4'd15, 48'h0, MAC_C},             0, '{32'h0, VD_FILTERED}},
            '{'{1'b1, 1'b1, 4'd15, 48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF},
              1, '{32'h0, VD_UNLINK}},
            '{'{1'b0, 1'b0, 4'd7, MAC_C, MAC_A},              0, '{32'h0, VD_FILTERED}},
            '{'{1'b0, 1'b0, 4'd0, 48'hFEFF_FFFF_FFFF, MAC_C}, 0, '{32'h0, VD_FILTERED}}
        };
        foreach (rows[i]) send(rows[i].it, rows[i].typed, rows[i].res);
        drain();

        // random phases over several register settings, extremes included
        for (int ph = 0; ph < 7; ph++) begin
            case (ph)
                0: configure(5'd16, 5'd16, 32'hFFFF_FFFF);
                1: configure(5'd0, 5'd31, $urandom);
                2: configure(5'd1, 5'd16, $urandom);
                3: configure(5'd31, 5'd0, 32'hFFFF_0000);
                4: begin
                    wv = 5'($urandom_range(1, 15));
                    ev = 5'($urandom_range(1, 15));
                    configure(wv, ev, $urandom);
                end
                5: configure(5'd16, 5'd16, 32'h0);
                default: configure(5'd16, 5'd1, 32'h0000_FFFF);
            endcase
            rx_calm = (ph == 3);
            for (int n = 0; n < RAND_ITEMS; n++) begin
                // hold off until every result is back once
                if (ph == 2 && n == RAND_ITEMS / 2) begin
                    i_valid = 1'b0;
                    @(negedge i_clk);
                    while (verdict_q.size() > 0) @(negedge i_clk);
                end
                it = random_item();
                send(it, 1'b0, '0);
            end
            drain();
        end

        $display("covered: filtered %0d, unicast %0d, multicast %0d, miss %0d",
                 seen[VD_FILTERED], seen[VD_UNICAST], seen[VD_MCAST], seen[VD_MISS]);
        $display("         stale %0d, unlink %0d; longest gap %0d, longest stall %0d",
                 seen[VD_STALE], seen[VD_UNLINK], tx_gap_max, rx_stall_max);
        if (errors == 0 && verdict_q.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("%0d mismatches, %0d results missing", errors, verdict_q.size());
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
